@@ hdl/gaps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gaps_pkg;

   localparam int GRID_SIDE  = 64;
   localparam int CELL_W     = 6;
   localparam int CELLS      = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W     = 12;
   localparam int NODE_LIMIT = 4096;
   localparam int CNT_W      = 13;
   localparam int F_W        = 16;
   localparam int COST_W     = 15;
   localparam int REC_W      = 12;
   localparam int DIR_W      = 4;
   localparam logic [DIR_W-1:0] NO_DIR = 4'd8;
   localparam logic [11:0] MAX_PATH = 12'd4095;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_SEARCH = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOPATH = 2'd1;
   localparam logic [1:0] ST_LIMIT  = 2'd2;
   localparam logic [1:0] ST_RANGE  = 2'd3;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MASK   = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_RD_WAIT, S_VCLR, S_ADD_CHK, S_ADD_EVAL, S_UP_CHK, S_UP_CMP,
      S_UP_PLACE, S_NEXT, S_POP_START, S_POP_TOP, S_POP_LAST, S_DN_CHK, S_DN_L,
      S_DN_R, S_DN_CMP, S_DN_PLACE, S_T1_RD, S_T1_EV, S_T2_RD, S_T2_WR, S_DONE
   } gaps_state_type;

   typedef struct packed {
      logic [CELL_W-1:0] x;
      logic [CELL_W-1:0] y;
      logic [F_W-1:0]    f;
      logic [COST_W-1:0] cost;
      logic [REC_W-1:0]  rec;
   } heap_entry_type;

   typedef struct packed {
      logic [DIR_W-1:0] dir;
      logic [REC_W-1:0] father;
   } node_rec_type;

   function automatic logic signed [7:0] step_dx(input logic [2:0] i);
      case (i)
         3'd1, 3'd2, 3'd3: step_dx = 8'sd1;
         3'd5, 3'd6, 3'd7: step_dx = -8'sd1;
         default:          step_dx = 8'sd0;
      endcase
   endfunction

   function automatic logic signed [7:0] step_dy(input logic [2:0] i);
      case (i)
         3'd0, 3'd1, 3'd7: step_dy = -8'sd1;
         3'd3, 3'd4, 3'd5: step_dy = 8'sd1;
         default:          step_dy = 8'sd0;
      endcase
   endfunction

endpackage
`default_nettype wire

@@ hdl/gaps_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface gaps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [5:0]  cell_x;
   logic [5:0]  cell_y;
   logic [7:0]  attribute;
   logic [5:0]  target_x;
   logic [5:0]  target_y;
   logic [11:0] step_index;
   modport source (output valid, kind, cell_x, cell_y, attribute, target_x, target_y,
                   step_index, input ready);
   modport sink (input valid, kind, cell_x, cell_y, attribute, target_x, target_y,
                 step_index, output ready);
endinterface
`default_nettype wire

@@ hdl/gaps_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface gaps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] path_length;
   logic [2:0]  step_dir;
   modport source (output valid, status, path_length, step_dir, input ready);
   modport sink (input valid, status, path_length, step_dir, output ready);
endinterface
`default_nettype wire

@@ hdl/gaps_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gaps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ hdl/grid_astar_path_search.sv @@
// Grid A* path search over a 64 x 64 attribute store.
// Cell write, kind three, out-of-range step read: S_DONE follows accept and loads the result
// register once the output is free. In-range path step read: S_RD_WAIT, then S_DONE. A new
// item is taken in the cycle after the result loads. Search: visited clear; per pop, heap
// sift-down; per neighbor, skip or heap add with sift-up; then the path is traced and stored.
// Reset: synchronous; a pass clears all 4096 attribute and visited cells, no item taken.
`timescale 1ns / 1ps
`default_nettype none
module grid_astar_path_search (
   input  wire logic       clock,
   input  wire logic       reset,
   gaps_req_if.sink        req_chan,
   gaps_rsp_if.source      rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);
   import gaps_pkg::*;

   gaps_state_type state_ff, state_in;
   logic [6:0] gw_ff, gw_in, gh_ff, gh_in;
   logic [7:0] mask_ff, mask_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic signed [7:0] cand_x_ff, cand_x_in, cand_y_ff, cand_y_in;
   logic [5:0] tx_ff, tx_in, ty_ff, ty_in;
   logic is_start_ff, is_start_in;
   logic [2:0] dir_ff, dir_in;
   logic [DIR_W-1:0] add_dir_ff, add_dir_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic [F_W-1:0] f_ff, f_in;
   heap_entry_type a_ff, a_in, last_ff, last_in, child_ff, child_in;
   logic [CNT_W-1:0] heap_cnt_ff, heap_cnt_in, node_cnt_ff, node_cnt_in, p_ff, p_in;
   logic [CNT_W:0] q_ff, q_in;
   logic [11:0] path_cnt_ff, path_cnt_in, len_ff, len_in, idx_ff, idx_in;
   logic [REC_W-1:0] k_ff, k_in;
   logic [1:0] res_status_ff, res_status_in;
   logic [2:0] res_dir_ff, res_dir_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [11:0] rsp_len_ff, rsp_len_in;
   logic [2:0] rsp_dir_ff, rsp_dir_in;

   logic attr_we, vis_we, vis_wd, heap_we, node_we, path_we;
   logic [ADDR_W-1:0] attr_wa, vis_wa, heap_wa, heap_ra, node_ra, path_wa, path_ra, cell_ra;
   logic [7:0] attr_wd, attr_rd;
   logic vis_rd;
   heap_entry_type heap_wd, heap_rd;
   node_rec_type node_wd, node_rd;
   logic [2:0] path_wd, path_rd;

   logic [6:0] gw_eff, gh_eff;
   logic req_fire, out_free, cand_on, skip_add, limit_hit, top_target, w_on;
   logic q_le, q_lt;
   logic [5:0] hdx, hdy, hdd;
   logic [10:0] heur;
   logic [2:0] dir_nx;
   logic signed [7:0] ax_s, ay_s;

   assign gw_eff = (gw_ff > 7'd64) ? 7'd64 : gw_ff;
   assign gh_eff = (gh_ff > 7'd64) ? 7'd64 : gh_ff;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign cand_on = !cand_x_ff[7] && !cand_y_ff[7] && (cand_x_ff[6:0] < gw_eff)
                    && (cand_y_ff[6:0] < gh_eff);
   assign cell_ra = {cand_y_ff[5:0], cand_x_ff[5:0]};
   assign limit_hit = (node_cnt_ff >= CNT_W'(NODE_LIMIT));
   assign skip_add = ((attr_rd & mask_ff) != 8'd0) || vis_rd || limit_hit;
   assign hdx = (cand_x_ff[5:0] > tx_ff) ? cand_x_ff[5:0] - tx_ff : tx_ff - cand_x_ff[5:0];
   assign hdy = (cand_y_ff[5:0] > ty_ff) ? cand_y_ff[5:0] - ty_ff : ty_ff - cand_y_ff[5:0];
   assign hdd = (hdx > hdy) ? hdx - hdy : hdy - hdx;
   assign heur = 11'((12'd7 * {6'd0, hdx} + 12'd7 * {6'd0, hdy} + 12'd3 * {6'd0, hdd}) >> 1);
   assign q_le = (q_ff <= {1'b0, heap_cnt_ff});
   assign q_lt = (q_ff < {1'b0, heap_cnt_ff});
   assign top_target = (a_ff.x == tx_ff) && (a_ff.y == ty_ff);
   assign w_on = ({1'b0, req_chan.cell_x} < gw_eff) && ({1'b0, req_chan.cell_y} < gh_eff);
   assign dir_nx = dir_ff + 3'd1;
   assign ax_s = {2'b00, a_ff.x};
   assign ay_s = {2'b00, a_ff.y};

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.path_length = rsp_len_ff;
   assign rsp_chan.step_dir = rsp_dir_ff;

   gaps_ram #(.WIDTH(8), .DEPTH(CELLS)) u_attr (
      .clock(clock), .we(attr_we), .waddr(attr_wa), .wdata(attr_wd),
      .raddr(cell_ra), .rdata(attr_rd));
   gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (
      .clock(clock), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
      .raddr(cell_ra), .rdata(vis_rd));
   gaps_ram #(.WIDTH($bits(heap_entry_type)), .DEPTH(NODE_LIMIT)) u_heap (
      .clock(clock), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
      .raddr(heap_ra), .rdata(heap_rd));
   gaps_ram #(.WIDTH($bits(node_rec_type)), .DEPTH(NODE_LIMIT)) u_node (
      .clock(clock), .we(node_we), .waddr(node_cnt_ff[REC_W-1:0]), .wdata(node_wd),
      .raddr(node_ra), .rdata(node_rd));
   gaps_ram #(.WIDTH(3), .DEPTH(NODE_LIMIT)) u_path (
      .clock(clock), .we(path_we), .waddr(path_wa), .wdata(path_wd),
      .raddr(path_ra), .rdata(path_rd));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.kind)
                  KIND_SEARCH: state_in = S_VCLR;
                  KIND_READ: state_in = (req_chan.step_index < path_cnt_ff) ? S_RD_WAIT
                                                                            : S_DONE;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RD_WAIT: state_in = S_DONE;
         S_VCLR: begin
            if (clr_ff == ADDR_W'(CELLS - 1)) state_in = S_ADD_CHK;
         end
         S_ADD_CHK: state_in = cand_on ? S_ADD_EVAL : S_NEXT;
         S_ADD_EVAL: state_in = skip_add ? S_NEXT : S_UP_CHK;
         S_UP_CHK: state_in = (p_ff > CNT_W'(1)) ? S_UP_CMP : S_UP_PLACE;
         S_UP_CMP: state_in = (f_ff < heap_rd.f) ? S_UP_CHK : S_UP_PLACE;
         S_UP_PLACE: state_in = S_NEXT;
         S_NEXT: begin
            if (is_start_ff) state_in = S_POP_START;
            else if (limit_hit) state_in = S_DONE;
            else if (dir_ff == 3'd7) state_in = S_POP_START;
            else state_in = S_ADD_CHK;
         end
         S_POP_START: state_in = (heap_cnt_ff == '0) ? S_DONE : S_POP_TOP;
         S_POP_TOP: state_in = S_POP_LAST;
         S_POP_LAST: state_in = S_DN_CHK;
         S_DN_CHK: state_in = q_le ? S_DN_L : S_DN_PLACE;
         S_DN_L: state_in = q_lt ? S_DN_R : S_DN_CMP;
         S_DN_R: state_in = S_DN_CMP;
         S_DN_CMP: state_in = (child_ff.f < last_ff.f) ? S_DN_CHK : S_DN_PLACE;
         S_DN_PLACE: state_in = top_target ? S_T1_RD : S_ADD_CHK;
         S_T1_RD: state_in = S_T1_EV;
         S_T1_EV: begin
            if (node_rd.dir == NO_DIR) state_in = S_T2_RD;
            else if (len_ff == MAX_PATH) state_in = S_DONE;
            else state_in = S_T1_RD;
         end
         S_T2_RD: state_in = (idx_ff == '0) ? S_DONE : S_T2_WR;
         S_T2_WR: state_in = S_T2_RD;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      gw_in = gw_ff; gh_in = gh_ff; mask_in = mask_ff;
      clr_in = clr_ff;
      cand_x_in = cand_x_ff; cand_y_in = cand_y_ff;
      tx_in = tx_ff; ty_in = ty_ff;
      is_start_in = is_start_ff; dir_in = dir_ff; add_dir_in = add_dir_ff;
      cost_in = cost_ff; f_in = f_ff;
      a_in = a_ff; last_in = last_ff; child_in = child_ff;
      heap_cnt_in = heap_cnt_ff; node_cnt_in = node_cnt_ff;
      p_in = p_ff; q_in = q_ff;
      path_cnt_in = path_cnt_ff; len_in = len_ff; idx_in = idx_ff; k_in = k_ff;
      res_status_in = res_status_ff; res_dir_in = res_dir_ff;
      rsp_valid_in = rsp_valid_ff; rsp_status_in = rsp_status_ff;
      rsp_len_in = rsp_len_ff; rsp_dir_in = rsp_dir_ff;
      attr_we = 1'b0; attr_wa = clr_ff; attr_wd = 8'd0;
      vis_we = 1'b0; vis_wa = clr_ff; vis_wd = 1'b0;
      heap_we = 1'b0; heap_wa = p_ff[ADDR_W-1:0] - ADDR_W'(1); heap_wd = child_ff;
      heap_ra = '0;
      node_we = 1'b0; node_wd = '{dir: add_dir_ff, father: a_ff.rec};
      node_ra = k_ff;
      path_we = 1'b0; path_wa = idx_ff - 12'd1; path_wd = node_rd.dir[2:0];
      path_ra = req_chan.step_index;

      if (csr_we) begin
         case (csr_index)
            REG_WIDTH:  gw_in = csr_data[6:0];
            REG_HEIGHT: gh_in = csr_data[6:0];
            REG_MASK:   mask_in = csr_data;
            default: ;
         endcase
      end
      if (rsp_chan.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            attr_we = 1'b1;
            vis_we = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            res_status_in = ST_OK;
            res_dir_in = 3'd0;
            if (req_fire) begin
               case (req_chan.kind)
                  KIND_WRITE: begin
                     attr_we = w_on;
                     attr_wa = {req_chan.cell_y, req_chan.cell_x};
                     attr_wd = req_chan.attribute;
                  end
                  KIND_SEARCH: begin
                     cand_x_in = {2'b00, req_chan.cell_x};
                     cand_y_in = {2'b00, req_chan.cell_y};
                     tx_in = req_chan.target_x;
                     ty_in = req_chan.target_y;
                     heap_cnt_in = '0;
                     node_cnt_in = '0;
                     path_cnt_in = '0;
                     clr_in = '0;
                     is_start_in = 1'b1;
                     add_dir_in = NO_DIR;
                     cost_in = '0;
                     a_in.rec = '0;
                  end
                  KIND_READ: begin
                     if (req_chan.step_index >= path_cnt_ff) res_status_in = ST_RANGE;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_WAIT: res_dir_in = path_rd;
         S_VCLR: begin
            vis_we = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
         end
         S_ADD_EVAL: begin
            if (!skip_add) begin
               f_in = F_W'({1'b0, cost_ff} + {5'd0, heur});
               heap_cnt_in = heap_cnt_ff + CNT_W'(1);
               p_in = heap_cnt_ff + CNT_W'(1);
            end
         end
         S_UP_CHK: heap_ra = p_ff[ADDR_W:1] - ADDR_W'(1);
         S_UP_CMP: begin
            if (f_ff < heap_rd.f) begin
               heap_we = 1'b1;
               heap_wd = heap_rd;
               p_in = p_ff >> 1;
            end
         end
         S_UP_PLACE: begin
            heap_we = 1'b1;
            heap_wd = '{x: cand_x_ff[5:0], y: cand_y_ff[5:0], f: f_ff, cost: cost_ff,
                        rec: node_cnt_ff[REC_W-1:0]};
            node_we = 1'b1;
            node_cnt_in = node_cnt_ff + CNT_W'(1);
            vis_we = 1'b1;
            vis_wa = cell_ra;
            vis_wd = 1'b1;
         end
         S_NEXT: begin
            is_start_in = 1'b0;
            if (!is_start_ff && limit_hit) begin
               res_status_in = ST_LIMIT;
               path_cnt_in = '0;
            end else if (!is_start_ff && dir_ff != 3'd7) begin
               dir_in = dir_nx;
               add_dir_in = {1'b0, dir_nx};
               cand_x_in = ax_s + step_dx(dir_nx);
               cand_y_in = ay_s + step_dy(dir_nx);
               cost_in = a_ff.cost + (dir_nx[0] ? COST_W'(7) : COST_W'(5));
            end
         end
         S_POP_START: begin
            heap_ra = '0;
            if (heap_cnt_ff == '0) begin
               res_status_in = ST_NOPATH;
               path_cnt_in = '0;
            end
         end
         S_POP_TOP: begin
            a_in = heap_rd;
            heap_ra = heap_cnt_ff[ADDR_W-1:0] - ADDR_W'(1);
            heap_cnt_in = heap_cnt_ff - CNT_W'(1);
         end
         S_POP_LAST: begin
            last_in = heap_rd;
            p_in = CNT_W'(1);
            q_in = (CNT_W + 1)'(2);
         end
         S_DN_CHK: heap_ra = q_ff[ADDR_W-1:0] - ADDR_W'(1);
         S_DN_L: begin
            child_in = heap_rd;
            heap_ra = q_ff[ADDR_W-1:0];
         end
         S_DN_R: begin
            if (heap_rd.f < child_ff.f) begin
               child_in = heap_rd;
               q_in = q_ff + (CNT_W + 1)'(1);
            end
         end
         S_DN_CMP: begin
            if (child_ff.f < last_ff.f) begin
               heap_we = 1'b1;
               p_in = q_ff[CNT_W-1:0];
               q_in = {q_ff[CNT_W-1:0], 1'b0};
            end
         end
         S_DN_PLACE: begin
            heap_we = 1'b1;
            heap_wd = last_ff;
            k_in = a_ff.rec;
            len_in = '0;
            dir_in = 3'd0;
            add_dir_in = '0;
            cand_x_in = ax_s + step_dx(3'd0);
            cand_y_in = ay_s + step_dy(3'd0);
            cost_in = a_ff.cost + COST_W'(5);
         end
         S_T1_EV: begin
            if (node_rd.dir == NO_DIR) begin
               k_in = a_ff.rec;
               idx_in = len_ff;
            end else if (len_ff == MAX_PATH) begin
               res_status_in = ST_LIMIT;
               path_cnt_in = '0;
            end else begin
               len_in = len_ff + 12'd1;
               k_in = node_rd.father;
            end
         end
         S_T2_RD: begin
            if (idx_ff == '0) begin
               path_cnt_in = len_ff;
               res_status_in = ST_OK;
            end
         end
         S_T2_WR: begin
            path_we = 1'b1;
            k_in = node_rd.father;
            idx_in = idx_ff - 12'd1;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_len_in = path_cnt_ff;
               rsp_dir_in = res_dir_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         gw_ff <= 7'd64;
         gh_ff <= 7'd64;
         mask_ff <= 8'd1;
         heap_cnt_ff <= '0;
         node_cnt_ff <= '0;
         path_cnt_ff <= '0;
         is_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         gw_ff <= gw_in;
         gh_ff <= gh_in;
         mask_ff <= mask_in;
         heap_cnt_ff <= heap_cnt_in;
         node_cnt_ff <= node_cnt_in;
         path_cnt_ff <= path_cnt_in;
         is_start_ff <= is_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_x_ff <= cand_x_in;
      cand_y_ff <= cand_y_in;
      tx_ff <= tx_in;
      ty_ff <= ty_in;
      dir_ff <= dir_in;
      add_dir_ff <= add_dir_in;
      cost_ff <= cost_in;
      f_ff <= f_in;
      a_ff <= a_in;
      last_ff <= last_in;
      child_ff <= child_in;
      p_ff <= p_in;
      q_ff <= q_in;
      len_ff <= len_in;
      idx_ff <= idx_in;
      k_ff <= k_in;
      res_status_ff <= res_status_in;
      res_dir_ff <= res_dir_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff <= rsp_len_in;
      rsp_dir_ff <= rsp_dir_in;
   end
endmodule
`default_nettype wire
